/* rtl/top_k_score_queue_core_assert.svh */
// Assertion macros for the top-k score queue core.
// Used by the top level only; the bodies are empty when SYNTHESIS is defined.
`ifndef TOP_K_SCORE_QUEUE_CORE_ASSERT_SVH
`define TOP_K_SCORE_QUEUE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TKSQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TKSQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TKSQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define TKSQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

/* rtl/tksq_pkg.sv */
// Shared types and constants of the top-k score queue core.
// No dependencies; imported by tksq_cell and top_k_score_queue_core.
`timescale 1ns / 1ps

package tksq_pkg;

	localparam int DEF_MAX_ENTRIES = 64;
	localparam int CNT_W = 7;
	localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

	typedef struct packed {
		logic signed [31:0] score;
		logic [31:0]        doc_id;
	} entry_t;

	typedef enum logic [1:0] {
		OP_HOLD    = 2'd0,
		OP_APPEND  = 2'd1,
		OP_COMPACT = 2'd2,
		OP_ROTATE  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [CNT_W-1:0] pos_a;
		logic [CNT_W-1:0] pos_b;
	} cell_ctl_t;

endpackage

/* rtl/tksq_cell.sv */
// One storage cell of the hit chain: holds a single entry and takes the entry of its
// right-hand neighbour, the head entry or the new hit as the broadcast control says.
// Depends on tksq_pkg.
`timescale 1ns / 1ps

module tksq_cell #(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  tksq_pkg::cell_ctl_t ctl,
	input  tksq_pkg::entry_t   next_entry,
	input  tksq_pkg::entry_t   head_entry,
	input  tksq_pkg::entry_t   new_entry,
	output tksq_pkg::entry_t   entry
);
	import tksq_pkg::*;

	entry_t entry_q;
	logic   at_a_or_above;
	logic   below_b;
	logic   at_b;

	assign at_a_or_above = IDX >= int'(ctl.pos_a);
	assign below_b       = IDX <  int'(ctl.pos_b);
	assign at_b          = IDX == int'(ctl.pos_b);

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_APPEND: begin
				if (at_b) begin
					entry_q <= new_entry;
				end
			end
			OP_COMPACT: begin
				if (at_a_or_above && below_b) begin
					entry_q <= next_entry;
				end else if (at_b) begin
					entry_q <= new_entry;
				end
			end
			OP_ROTATE: begin
				if (below_b) begin
					entry_q <= next_entry;
				end else if (at_b) begin
					entry_q <= head_entry;
				end
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

	assign entry = entry_q;

endmodule

/* rtl/top_k_score_queue_core.sv */
// Top level of the top-k score queue core: control, result register and the cell chain.
// Depends on tksq_pkg, tksq_cell and top_k_score_queue_core_assert.svh.
`timescale 1ns / 1ps
`include "top_k_score_queue_core_assert.svh"

// Usage
// Hits enter on the in channel (doc_id, score) and each transfer yields exactly one
// result on the out channel. Capacity is written through cfg_we and cfg_wdata; the
// user must write it only while the block is idle, which the block does not enforce;
// a value of 0 acts as 1 and a value above MAX_ENTRIES acts as MAX_ENTRIES.
// Hits are kept in arrival order in a chain of MAX_ENTRIES cells, head at cell 0.
// While a free slot exists the hit is appended in S_EXEC and the result is loaded
// in S_PUSH once the output register is free. When full, S_EXEC evicts the held
// minimum by shifting the later cells down and appending the new hit, then S_SCAN
// rotates the chain once per cycle through its held entries while the head is
// compared, giving the new minimum, and S_PUSH loads the result.
// One item is in flight at a time: in_ready is high only between items, so a new hit
// is taken only after the previous one has left S_PUSH.
// A finished result waits in the output register while the receiver stalls, and the
// next hit may be taken meanwhile; its result then waits for the register to drain.
// Reset clears the held count and sets capacity to 64; entries are not cleared.
module top_k_score_queue_core #(
	parameter int MAX_ENTRIES = tksq_pkg::DEF_MAX_ENTRIES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [tksq_pkg::CNT_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [31:0]               doc_id,
	input  logic signed [31:0]        score,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      took_free_slot,
	output logic [31:0]               evicted_doc_id,
	output logic signed [31:0]        evicted_score,
	output logic signed [31:0]        min_score,
	output logic [tksq_pkg::CNT_W-1:0] held_count,
	output logic                      is_full
);
	import tksq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_SCAN = 4'b0100,
		S_PUSH = 4'b1000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cap_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] min_idx_q;
	logic [CNT_W-1:0] scan_q;
	entry_t           min_q;
	entry_t           new_q;
	entry_t           evict_q;
	logic             took_q;

	logic             out_valid_q;
	logic             took_out_q;
	entry_t           evict_out_q;
	logic signed [31:0] min_out_q;
	logic [CNT_W-1:0] count_out_q;
	logic             full_out_q;

	logic [CNT_W-1:0] eff_cap;
	logic             store_full;
	logic [CNT_W-1:0] last_pos;
	logic             out_free;
	cell_ctl_t        ctl;
	entry_t           head_entry;
	entry_t           cell_entry [MAX_ENTRIES];

	always_comb begin
		eff_cap = cap_q;
		if (cap_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (int'(cap_q) > MAX_ENTRIES) begin
			eff_cap = CNT_W'(MAX_ENTRIES);
		end
	end

	assign store_full = count_q >= eff_cap;
	assign last_pos   = count_q - CNT_W'(1);
	assign out_free   = !out_valid_q || out_ready;
	assign head_entry = cell_entry[0];

	always_comb begin
		ctl.op    = OP_HOLD;
		ctl.pos_a = '0;
		ctl.pos_b = '0;
		case (state_q)
			S_EXEC: begin
				if (store_full) begin
					ctl.op    = OP_COMPACT;
					ctl.pos_a = min_idx_q;
					ctl.pos_b = last_pos;
				end else begin
					ctl.op    = OP_APPEND;
					ctl.pos_b = count_q;
				end
			end
			S_SCAN: begin
				ctl.op    = OP_ROTATE;
				ctl.pos_b = last_pos;
			end
			default: begin
				ctl.op = OP_HOLD;
			end
		endcase
	end

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_chain
		entry_t next_entry;
		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign next_entry = head_entry;
		end else begin : g_body
			assign next_entry = cell_entry[i+1];
		end
		tksq_cell #(
			.IDX(i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.next_entry(next_entry),
			.head_entry(head_entry),
			.new_entry (new_q),
			.entry     (cell_entry[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			min_idx_q <= '0;
			scan_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (store_full) begin
						scan_q  <= '0;
						state_q <= S_SCAN;
					end else begin
						if (count_q == '0 || new_q.score < min_q.score) begin
							min_idx_q <= count_q;
						end
						count_q <= count_q + CNT_W'(1);
						state_q <= S_PUSH;
					end
				end
				S_SCAN: begin
					if (scan_q == '0 || head_entry.score < min_q.score) begin
						min_idx_q <= scan_q;
					end
					scan_q <= scan_q + CNT_W'(1);
					if (scan_q == last_pos) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					new_q.doc_id <= doc_id;
					new_q.score  <= score;
				end
			end
			S_EXEC: begin
				if (store_full) begin
					took_q  <= 1'b0;
					evict_q <= min_q;
				end else begin
					took_q  <= 1'b1;
					evict_q <= '0;
					if (count_q == '0 || new_q.score < min_q.score) begin
						min_q <= new_q;
					end
				end
			end
			S_SCAN: begin
				if (scan_q == '0 || head_entry.score < min_q.score) begin
					min_q <= head_entry;
				end
			end
			default: begin
				min_q <= min_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_PUSH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PUSH && out_free) begin
			took_out_q  <= took_q;
			evict_out_q <= evict_q;
			min_out_q   <= min_q.score;
			count_out_q <= count_q;
			full_out_q  <= store_full;
		end
	end

	assign in_ready       = state_q == S_IDLE;
	assign out_valid      = out_valid_q;
	assign took_free_slot = took_out_q;
	assign evicted_doc_id = evict_out_q.doc_id;
	assign evicted_score  = evict_out_q.score;
	assign min_score      = min_out_q;
	assign held_count     = count_out_q;
	assign is_full        = full_out_q;

	`TKSQ_ASSERT(a_result_holds_hit, clk, arst_n, out_valid |-> held_count != '0, "result reports an empty store")
	`TKSQ_ASSERT(a_free_slot_no_evict, clk, arst_n, (out_valid && took_free_slot) |-> (evicted_doc_id == '0 && evicted_score == '0), "free slot result carries an eviction")
	`TKSQ_ASSERT(a_scan_count_stable, clk, arst_n, (state_q == S_SCAN) |-> $stable(count_q), "held count changed during the minimum scan")
	`TKSQ_ASSERT_NEVER(a_count_shrinks, clk, arst_n, count_q < $past(count_q), "held count decreased")

endmodule
